// ===== rtl/core/brle8_pkg.sv =====
// ----------------------------------------------------------------------------
// brle8_pkg
// Shared types for the 8-bit BMP RLE run decoder: the handshake status of the
// iterative divider that the sequencer drives.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package brle8_pkg;

  // Divider status seen by the sequencer
  typedef struct packed {
    logic busy;  // iterations in progress
    logic done;  // one-cycle pulse, quotient and remainder valid
  } div_stat_t;

endpackage : brle8_pkg

// ===== rtl/core/brle8_div.sv =====
// ----------------------------------------------------------------------------
// brle8_div
// Restoring radix-2 divider, one quotient bit per cycle. A start pulse loads
// the operands; after the last quotient bit done pulses and the results hold
// until the next start.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module brle8_div #(
  parameter int unsigned DVD_W = 25,
  parameter int unsigned DVS_W = 13
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic [DVD_W-1:0]       dividend_i,
  input  logic [DVS_W-1:0]       divisor_i,
  output brle8_pkg::div_stat_t   stat_o,
  output logic [DVD_W-1:0]       quot_o,
  output logic [DVS_W-1:0]       rem_o
);

  localparam int unsigned CNT_W = $clog2(DVD_W + 1);

  logic [DVD_W-1:0] dq_q, dq_d;   // dividend shifting out, quotient shifting in
  logic [DVS_W-1:0] d_q;
  logic [DVS_W-1:0] r_q, r_d;
  logic [CNT_W-1:0] cnt_q;
  logic             busy_q, done_q;

  logic [DVS_W:0]   trial;
  logic [DVS_W:0]   diff;
  logic             ge;

  // One restoring step
  always_comb begin
    trial = {r_q, dq_q[DVD_W-1]};
    diff  = trial - {1'b0, d_q};
    ge    = (trial >= {1'b0, d_q});
    r_d   = ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
    dq_d  = {dq_q[DVD_W-2:0], ge};
  end

  // Control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(DVD_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dq_q <= dividend_i;
      d_q  <= divisor_i;
      r_q  <= '0;
    end else if (busy_q) begin
      dq_q <= dq_d;
      r_q  <= r_d;
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quot_o      = dq_q;
  assign rem_o       = r_q;

endmodule : brle8_div

// ===== rtl/core/bmp_rle8_run_decoder.sv =====
// ----------------------------------------------------------------------------
// bmp_rle8_run_decoder
// Takes an 8-bit BMP RLE stream one byte per item and gives one
// (pixel_value, run_length, image_done) item per decoded run: encoded runs,
// single literal pixels, and zero-valued fills for end of line, end of bitmap
// and delta, all clipped at the last pixel of the image. A byte that only
// advances the parser (count, escape code, pad, delta x) leaves the sequencer
// idle and the input ready. A byte that makes a run goes through a small
// sequencer that shares one multiplier and one bit-serial divider: it takes the
// image limit, the position and the pixels left, then the delta length or, for
// end of line, the column from the divider, clips the run, and has the divider
// split the new position into row and column before the run goes out. The
// input is not ready while a run is in work; a finished run waits in the
// output register. Width and height are to be written through the
// configuration port only while idle; the block itself does not enforce it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bmp_rle8_run_decoder #(
  parameter int unsigned MAX_WIDTH  = 4096,
  parameter int unsigned MAX_HEIGHT = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [12:0] cfg_wdata_i,
  // compressed byte in
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  code_byte_i,
  // run out
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  pixel_value_o,
  output logic [24:0] run_length_o,
  output logic        image_done_o
);

  localparam int unsigned RUN_W = 25;
  localparam longint unsigned POS_SPAN =
      longint'(MAX_WIDTH) * (longint'(MAX_HEIGHT) + 64'd1);
  localparam longint unsigned DLT_SPAN = longint'(MAX_WIDTH) * 64'd256 + 64'd256;
  localparam int unsigned POS_W = $clog2(POS_SPAN);
  localparam int unsigned LEN_W =
      $clog2(((DLT_SPAN > POS_SPAN) ? DLT_SPAN : POS_SPAN) + 64'd1);
  localparam int unsigned WD_W  = $clog2(MAX_WIDTH + 1);
  localparam int unsigned COL_W = $clog2(MAX_WIDTH);
  localparam int unsigned ROW_W = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned MB_W  = (ROW_W > 8) ? ROW_W : 8;
  localparam int unsigned MC_W  = (COL_W > 8) ? COL_W : 8;
  localparam int unsigned PR_W  = WD_W + MB_W + 1;

  // Configuration register indexes
  localparam logic CFG_WIDTH  = 1'b0;
  localparam logic CFG_HEIGHT = 1'b1;

  // Parse phases
  localparam logic [2:0] PH_COUNT   = 3'd0;
  localparam logic [2:0] PH_VALUE   = 3'd1;
  localparam logic [2:0] PH_ESCAPE  = 3'd2;
  localparam logic [2:0] PH_LITERAL = 3'd3;
  localparam logic [2:0] PH_PAD     = 3'd4;
  localparam logic [2:0] PH_DX      = 3'd5;
  localparam logic [2:0] PH_DY      = 3'd6;

  // Escape codes after a zero count byte
  localparam logic [7:0] ESC_EOL   = 8'd0;
  localparam logic [7:0] ESC_EOB   = 8'd1;
  localparam logic [7:0] ESC_DELTA = 8'd2;

  // Run kinds
  localparam logic [1:0] RK_FIXED = 2'd0;
  localparam logic [1:0] RK_EOL   = 2'd1;
  localparam logic [1:0] RK_EOB   = 2'd2;
  localparam logic [1:0] RK_DELTA = 2'd3;

  // Sequencer states
  localparam logic [3:0] SQ_IDLE = 4'd0;
  localparam logic [3:0] SQ_LIM  = 4'd1;
  localparam logic [3:0] SQ_POS  = 4'd2;
  localparam logic [3:0] SQ_REM  = 4'd3;
  localparam logic [3:0] SQ_LEN  = 4'd4;
  localparam logic [3:0] SQ_DIVX = 4'd5;
  localparam logic [3:0] SQ_CLIP = 4'd6;
  localparam logic [3:0] SQ_DIVN = 4'd7;
  localparam logic [3:0] SQ_EMIT = 4'd8;

  logic [12:0]      width_q, width_d, height_q, height_d;
  logic [2:0]       phase_q, phase_d;
  logic [COL_W-1:0] col_q, col_d;
  logic [ROW_W-1:0] row_q, row_d;
  logic [7:0]       pend_q, pend_d;
  logic             pad_q, pad_d;
  logic [7:0]       dx_q, dx_d;
  logic [3:0]       sq_q, sq_d;
  logic [1:0]       kind_q, kind_d;
  logic [7:0]       byte_q, byte_d;
  logic [LEN_W-1:0] len_q, len_d;
  logic [POS_W-1:0] limit_q, limit_d, pos_q, pos_d, rem_q, rem_d;
  logic [POS_W-1:0] run_q, run_d;
  logic             fin_q, fin_d;
  logic             out_valid_q, out_valid_d;
  logic [7:0]       out_val_q, out_val_d;
  logic [RUN_W-1:0] out_run_q, out_run_d;
  logic             out_done_q, out_done_d;

  logic             in_acc;
  logic [7:0]       pend_dec;
  logic [31:0]      w_raw, h_raw;
  logic [WD_W-1:0]  w_eff;
  logic [ROW_W-1:0] h_eff;
  logic [MB_W-1:0]  mul_b;
  logic [MC_W-1:0]  mul_c;
  logic [PR_W-1:0]  mul_res;
  logic [POS_W-1:0] rem_calc;
  logic [LEN_W-1:0] rem_ext, run_min;
  logic [POS_W-1:0] run_pos, npos;
  logic             emit_load;

  logic                 div_start;
  logic [POS_W-1:0]     div_dvd;
  brle8_pkg::div_stat_t div_stat;
  logic [POS_W-1:0]     div_quot;
  logic [WD_W-1:0]      div_rem;

  assign in_ready_o = (sq_q == SQ_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign pend_dec   = (pend_q != 8'd0) ? pend_q - 8'd1 : 8'd0;

  // Effective image size: zero acts as one, clamp at the bounds
  always_comb begin
    w_raw = 32'(width_q);
    h_raw = 32'(height_q);
    if (width_q == 13'd0)         w_eff = WD_W'(1);
    else if (w_raw > MAX_WIDTH)   w_eff = WD_W'(MAX_WIDTH);
    else                          w_eff = WD_W'(w_raw);
    if (height_q == 13'd0)        h_eff = ROW_W'(1);
    else if (h_raw > MAX_HEIGHT)  h_eff = ROW_W'(MAX_HEIGHT);
    else                          h_eff = ROW_W'(h_raw);
  end

  // Shared multiply-add: width times (height | row | dy) plus (0 | column | dx)
  always_comb begin
    unique case (sq_q)
      SQ_LIM: begin
        mul_b = MB_W'(h_eff);
        mul_c = '0;
      end
      SQ_POS: begin
        mul_b = MB_W'(row_q);
        mul_c = MC_W'(col_q);
      end
      default: begin
        mul_b = MB_W'(byte_q);
        mul_c = MC_W'(dx_q);
      end
    endcase
    mul_res = PR_W'(w_eff) * PR_W'(mul_b) + PR_W'(mul_c);
  end

  // Pixels left to the image end, and the clipped run
  always_comb begin
    rem_calc = (pos_q < limit_q) ? limit_q - pos_q : '0;
    rem_ext  = LEN_W'(rem_q);
    run_min  = (len_q < rem_ext) ? len_q : rem_ext;
    run_pos  = POS_W'(run_min);
    npos     = pos_q + run_pos;
  end

  assign div_dvd   = (sq_q == SQ_REM) ? pos_q : npos;
  assign emit_load = (sq_q == SQ_EMIT) && (!out_valid_q || out_ready_i);

  // Parser and sequencer
  always_comb begin
    width_d    = width_q;
    height_d   = height_q;
    phase_d    = phase_q;
    col_d      = col_q;
    row_d      = row_q;
    pend_d     = pend_q;
    pad_d      = pad_q;
    dx_d       = dx_q;
    sq_d       = sq_q;
    kind_d     = kind_q;
    byte_d     = byte_q;
    len_d      = len_q;
    limit_d    = limit_q;
    pos_d      = pos_q;
    rem_d      = rem_q;
    run_d      = run_q;
    fin_d      = fin_q;
    div_start  = 1'b0;
    out_val_d  = out_val_q;
    out_run_d  = out_run_q;
    out_done_d = out_done_q;

    // configuration writes
    if (cfg_we_i) begin
      if (cfg_index_i == CFG_WIDTH) width_d = cfg_wdata_i;
      else if (cfg_index_i == CFG_HEIGHT) height_d = cfg_wdata_i;
    end

    unique case (sq_q)
      SQ_IDLE: begin
        if (in_acc) begin
          byte_d = code_byte_i;
          len_d  = LEN_W'(1);
          unique case (phase_q)
            PH_VALUE: begin
              phase_d = PH_COUNT;
              kind_d  = RK_FIXED;
              len_d   = LEN_W'(pend_q);
              sq_d    = SQ_LIM;
            end
            PH_ESCAPE: begin
              if (code_byte_i > ESC_DELTA) begin
                pend_d  = code_byte_i;
                pad_d   = code_byte_i[0];
                phase_d = PH_LITERAL;
              end else if (code_byte_i == ESC_DELTA) begin
                phase_d = PH_DX;
              end else begin
                phase_d = PH_COUNT;
                if (code_byte_i == ESC_EOL) kind_d = RK_EOL;
                else if (code_byte_i == ESC_EOB) kind_d = RK_EOB;
                sq_d    = SQ_LIM;
              end
            end
            PH_LITERAL: begin
              pend_d = pend_dec;
              if (pend_dec == 8'd0) phase_d = pad_q ? PH_PAD : PH_COUNT;
              kind_d = RK_FIXED;
              sq_d   = SQ_LIM;
            end
            PH_PAD: begin
              pad_d   = 1'b0;
              phase_d = PH_COUNT;
            end
            PH_DX: begin
              dx_d    = code_byte_i;
              phase_d = PH_DY;
            end
            PH_DY: begin
              phase_d = PH_COUNT;
              kind_d  = RK_DELTA;
              sq_d    = SQ_LIM;
            end
            default: begin
              // count byte; unused codes parse the same way
              if (code_byte_i != 8'd0) begin
                pend_d  = code_byte_i;
                phase_d = PH_VALUE;
              end else begin
                phase_d = PH_ESCAPE;
              end
            end
          endcase
        end
      end
      SQ_LIM: begin
        limit_d = POS_W'(mul_res);
        sq_d    = SQ_POS;
      end
      SQ_POS: begin
        pos_d = POS_W'(mul_res);
        sq_d  = SQ_REM;
      end
      SQ_REM: begin
        rem_d = rem_calc;
        unique case (kind_q)
          RK_EOL: begin
            div_start = 1'b1;
            sq_d      = SQ_DIVX;
          end
          RK_EOB: begin
            len_d = LEN_W'(rem_calc);
            sq_d  = SQ_CLIP;
          end
          RK_DELTA: sq_d = SQ_LEN;
          default:  sq_d = SQ_CLIP;
        endcase
      end
      SQ_LEN: begin
        len_d = LEN_W'(mul_res);
        sq_d  = SQ_CLIP;
      end
      SQ_DIVX: begin
        // column of the current position; none to fill at column zero
        if (div_stat.done) begin
          if (div_rem == '0) begin
            sq_d = SQ_IDLE;
          end else begin
            len_d = LEN_W'(w_eff - div_rem);
            sq_d  = SQ_CLIP;
          end
        end
      end
      SQ_CLIP: begin
        if (run_min == '0) begin
          sq_d = SQ_IDLE;
        end else begin
          run_d     = run_pos;
          fin_d     = (run_pos == rem_q);
          div_start = 1'b1;
          sq_d      = SQ_DIVN;
        end
      end
      SQ_DIVN: begin
        if (div_stat.done) begin
          row_d = ROW_W'(div_quot);
          col_d = COL_W'(div_rem);
          sq_d  = SQ_EMIT;
        end
      end
      SQ_EMIT: begin
        if (emit_load) begin
          out_val_d  = (kind_q == RK_FIXED) ? byte_q : 8'd0;
          out_run_d  = RUN_W'(run_q);
          out_done_d = fin_q;
          sq_d       = SQ_IDLE;
        end
      end
      default: sq_d = SQ_IDLE;
    endcase
  end

  // Output register valid
  always_comb begin
    if (emit_load)        out_valid_d = 1'b1;
    else if (out_ready_i) out_valid_d = 1'b0;
    else                  out_valid_d = out_valid_q;
  end

  // Control and parse state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q     <= 13'd640;
      height_q    <= 13'd480;
      phase_q     <= PH_COUNT;
      col_q       <= '0;
      row_q       <= '0;
      pend_q      <= 8'd0;
      pad_q       <= 1'b0;
      dx_q        <= 8'd0;
      sq_q        <= SQ_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      width_q     <= width_d;
      height_q    <= height_d;
      phase_q     <= phase_d;
      col_q       <= col_d;
      row_q       <= row_d;
      pend_q      <= pend_d;
      pad_q       <= pad_d;
      dx_q        <= dx_d;
      sq_q        <= sq_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Run datapath and output payload
  always_ff @(posedge clk_i) begin
    kind_q     <= kind_d;
    byte_q     <= byte_d;
    len_q      <= len_d;
    limit_q    <= limit_d;
    pos_q      <= pos_d;
    rem_q      <= rem_d;
    run_q      <= run_d;
    fin_q      <= fin_d;
    out_val_q  <= out_val_d;
    out_run_q  <= out_run_d;
    out_done_q <= out_done_d;
  end

  // Position split and end-of-line column
  brle8_div #(
    .DVD_W (POS_W),
    .DVS_W (WD_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (w_eff),
    .stat_o     (div_stat),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  assign out_valid_o   = out_valid_q;
  assign pixel_value_o = out_val_q;
  assign run_length_o  = out_run_q;
  assign image_done_o  = out_done_q;

  // A run is handed over only with a nonzero length
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (sq_q == SQ_EMIT) |-> (run_q != '0))
    else $error("empty run reached the output stage");

  // Divider results arrive only while the sequencer waits for them
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_stat.done |-> (sq_q == SQ_DIVX || sq_q == SQ_DIVN))
    else $error("divider finished outside a wait state");

  // No new byte is taken while the divider is iterating
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !div_stat.busy)
    else $error("input ready while divider busy");

  // A run waiting on a full output stage stays put
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (sq_q == SQ_EMIT && out_valid_q && !out_ready_i) |=> (sq_q == SQ_EMIT))
    else $error("run dropped while output stage full");

endmodule : bmp_rle8_run_decoder

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for bmp_rle8_run_decoder. Byte streams of encoded runs,
// literals, escapes, deltas and stray bytes go in under bursty input timing
// and a patterned output stall. A bit-exact model of the parser predicts every
// run, and each output item is compared with the oldest prediction. Image
// sizes change between phases, out-of-range values and the bounds included.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

  localparam int unsigned MAX_W         = 4096;
  localparam int unsigned MAX_H         = 4096;
  localparam int unsigned SETTLE_CYCLES = 100;     // idle time after the last run is back
  localparam int unsigned HOLD_CYCLES   = 400;     // long output hold-off
  localparam int unsigned HOLD_AFTER    = 100;     // runs seen before hold-off
  localparam int unsigned CYCLE_LIMIT   = 500_000;

  // Register indexes
  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  // Escape codes, second byte after a zero count
  localparam logic [7:0] ESC_INTRO = 8'd0;
  localparam logic [7:0] ESC_EOL   = 8'd0;
  localparam logic [7:0] ESC_EOB   = 8'd1;
  localparam logic [7:0] ESC_DELTA = 8'd2;
  localparam logic [7:0] LIT_MIN   = 8'd3;

  typedef enum logic [2:0] {
    PH_COUNT, PH_VALUE, PH_ESCAPE, PH_LITERAL, PH_PAD, PH_DX, PH_DY
  } parse_phase_e;

  typedef struct packed {
    logic [7:0]  pixel_value;
    logic [24:0] run_length;
    logic        image_done;
  } run_t;

  // DUT ports
  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        cfg_we_i      = 1'b0;
  logic        cfg_index_i   = 1'b0;
  logic [12:0] cfg_wdata_i   = '0;
  logic        in_valid_i    = 1'b0;
  logic        in_ready_o;
  logic [7:0]  code_byte_i   = '0;
  logic        out_valid_o;
  logic        out_ready_i   = 1'b0;
  logic [7:0]  pixel_value_o;
  logic [24:0] run_length_o;
  logic        image_done_o;

  bmp_rle8_run_decoder #(
    .MAX_WIDTH (MAX_W),
    .MAX_HEIGHT(MAX_H)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .code_byte_i  (code_byte_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .pixel_value_o(pixel_value_o),
    .run_length_o (run_length_o),
    .image_done_o (image_done_o)
  );

  // Stimulus and prediction stores
  logic [7:0] code_stream[$];
  run_t       pending_runs[$];

  // Decoder model state and register copies
  logic [12:0]       reg_width  = 13'd640;
  logic [12:0]       reg_height = 13'd480;
  parse_phase_e      dec_phase  = PH_COUNT;
  longint unsigned   cur_col    = 0;
  longint unsigned   cur_row    = 0;
  logic [7:0]        lit_left   = '0;
  logic              pad_flag   = 1'b0;
  logic [7:0]        held_dx    = '0;

  // Bookkeeping
  int unsigned bytes_sent = 0;
  int unsigned runs_seen  = 0;
  int unsigned err_cnt    = 0;
  int unsigned size_sets  = 0;
  int unsigned burst_left = 0;
  int unsigned gap_left   = 0;
  int unsigned hold_left  = 0;
  bit          hold_done  = 1'b0;
  int unsigned rx_cycle   = 0;
  int unsigned cycle_cnt  = 0;

  // Clock
  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // Decoder model
  // --------------------------------------------------------------------------
  function automatic longint unsigned eff_dim(logic [12:0] r, longint unsigned bound);
    if (r == 0) return 64'd1;
    if (r > bound) return bound;
    return 64'(r);
  endfunction

  // Clip a run at the image end, advance the position, queue it if any pixels are left
  task put_run(input logic [7:0] value, input longint unsigned len);
    longint unsigned w, lim, pos, rem, npos, clipped;
    run_t r;
    w = eff_dim(reg_width, MAX_W);
    lim = w * eff_dim(reg_height, MAX_H);
    pos = cur_row * w + cur_col;
    rem = (pos < lim) ? (lim - pos) : 0;
    clipped = (len > rem) ? rem : len;
    if (clipped != 0) begin
      npos = pos + clipped;
      cur_row = npos / w;
      cur_col = npos % w;
      r.pixel_value = value;
      r.run_length  = clipped[24:0];
      r.image_done  = (npos == lim);
      pending_runs.push_back(r);
    end
  endtask

  // Parse one accepted byte
  task decode_byte(input logic [7:0] b);
    longint unsigned w, lim, pos;
    w = eff_dim(reg_width, MAX_W);
    case (dec_phase)
      PH_VALUE: begin
        dec_phase = PH_COUNT;
        put_run(b, 64'(lit_left));
      end
      PH_ESCAPE: begin
        if (b >= LIT_MIN) begin
          lit_left  = b;
          pad_flag  = b[0];
          dec_phase = PH_LITERAL;
        end else if (b == ESC_DELTA) begin
          dec_phase = PH_DX;
        end else begin
          dec_phase = PH_COUNT;
          pos = cur_row * w + cur_col;
          if (b == ESC_EOL) begin
            // nothing to fill at the start of a row
            if (pos % w != 0) put_run(8'd0, w - pos % w);
          end else begin
            lim = w * eff_dim(reg_height, MAX_H);
            put_run(8'd0, (pos < lim) ? (lim - pos) : 0);
          end
        end
      end
      PH_LITERAL: begin
        if (lit_left != 0) lit_left = lit_left - 8'd1;
        if (lit_left == 0) dec_phase = pad_flag ? PH_PAD : PH_COUNT;
        put_run(b, 64'd1);
      end
      PH_PAD: begin
        pad_flag  = 1'b0;
        dec_phase = PH_COUNT;
      end
      PH_DX: begin
        held_dx   = b;
        dec_phase = PH_DY;
      end
      PH_DY: begin
        dec_phase = PH_COUNT;
        put_run(8'd0, w * b + held_dx);
      end
      default: begin
        if (b != 0) begin
          lit_left  = b;
          dec_phase = PH_VALUE;
        end else begin
          dec_phase = PH_ESCAPE;
        end
      end
    endcase
  endtask

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  function automatic logic [7:0] rand_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [12:0] rows_ahead(int unsigned k);
    longint unsigned h;
    h = cur_row + k;
    if (h > MAX_H) h = MAX_H;
    return h[12:0];
  endfunction

  // Mostly well-formed sequences with random content, some stray bytes
  task automatic feed_stream(int unsigned n_bytes, int unsigned max_run, bit with_eob);
    int unsigned added, kind, cnt, lit_max;
    logic [7:0] cb;
    added = 0;
    lit_max = (max_run < LIT_MIN) ? LIT_MIN : max_run;
    while (added < n_bytes) begin
      kind = $urandom_range(0, 99);
      if (kind < 45) begin
        cnt = $urandom_range(1, max_run);
        cb = 8'(cnt);
        code_stream.push_back(cb);
        code_stream.push_back(rand_byte());
        added += 2;
      end else if (kind < 70) begin
        if ($urandom_range(0, 9) == 0) cnt = $urandom_range(LIT_MIN, lit_max);
        else cnt = $urandom_range(LIT_MIN, (lit_max < 12) ? lit_max : 12);
        cb = 8'(cnt);
        code_stream.push_back(ESC_INTRO);
        code_stream.push_back(cb);
        repeat (cnt) code_stream.push_back(rand_byte());
        if (cb[0]) code_stream.push_back(rand_byte());
        added += 2 + cnt + cb[0];
      end else if (kind < 80) begin
        code_stream.push_back(ESC_INTRO);
        code_stream.push_back(ESC_EOL);
        added += 2;
      end else if (kind < 90) begin
        code_stream.push_back(ESC_INTRO);
        code_stream.push_back(ESC_DELTA);
        code_stream.push_back(rand_byte());
        if ($urandom_range(0, 9) < 7) cb = 8'($urandom_range(0, 2));
        else cb = rand_byte();
        code_stream.push_back(cb);
        added += 4;
      end else if (kind < 92) begin
        code_stream.push_back(ESC_INTRO);
        code_stream.push_back(with_eob ? ESC_EOB : ESC_EOL);
        added += 2;
      end else begin
        code_stream.push_back(rand_byte());
        added += 1;
      end
    end
  endtask

  task write_reg(input logic idx, input logic [12:0] data);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= data;
    if (idx == REG_WIDTH) reg_width = data;
    else reg_height = data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task set_size(input logic [12:0] w, input logic [12:0] h);
    write_reg(REG_WIDTH, w);
    write_reg(REG_HEIGHT, h);
    size_sets++;
    @(negedge clk_i);
  endtask

  // Wait until all bytes are sent and all runs are back, then let the block drain
  task wait_idle();
    @(negedge clk_i);
    while (code_stream.size() != 0 || in_valid_i || pending_runs.size() != 0)
      @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // --------------------------------------------------------------------------
  // Input driver: bursts of items with random gaps
  // --------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i  <= 1'b0;
      code_byte_i <= '0;
      burst_left  <= 0;
      gap_left    <= 0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        decode_byte(code_byte_i);
        bytes_sent++;
      end
      if (!in_valid_i || in_ready_o) begin
        if (gap_left != 0) begin
          gap_left   <= gap_left - 1;
          in_valid_i <= 1'b0;
        end else if (code_stream.size() != 0) begin
          code_byte_i <= code_stream.pop_front();
          in_valid_i  <= 1'b1;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 24);
            gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Output stall pattern, with one long hold-off
  // --------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      hold_left   <= 0;
      hold_done   <= 1'b0;
      rx_cycle    <= 0;
    end else begin
      rx_cycle <= rx_cycle + 1;
      if (hold_left != 0) begin
        hold_left   <= hold_left - 1;
        out_ready_i <= 1'b0;
      end else if (!hold_done && runs_seen >= HOLD_AFTER) begin
        hold_left   <= HOLD_CYCLES;
        hold_done   <= 1'b1;
        out_ready_i <= 1'b0;
      end else begin
        case ((rx_cycle >> 8) % 4)
          0: out_ready_i <= 1'b1;
          1: out_ready_i <= 1'($urandom_range(0, 1));
          2: out_ready_i <= (rx_cycle % 4 == 0);
          default: out_ready_i <= ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: compare each run with the oldest prediction
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    run_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      runs_seen <= runs_seen + 1;
      if (pending_runs.size() == 0) begin
        $error("unexpected run: pixel_value %0d run_length %0d image_done %0b",
               pixel_value_o, run_length_o, image_done_o);
        err_cnt++;
      end else begin
        want = pending_runs.pop_front();
        if (pixel_value_o !== want.pixel_value) begin
          $error("pixel_value: expected %0d, got %0d", want.pixel_value, pixel_value_o);
          err_cnt++;
        end
        if (run_length_o !== want.run_length) begin
          $error("run_length: expected %0d, got %0d", want.run_length, run_length_o);
          err_cnt++;
        end
        if (image_done_o !== want.image_done) begin
          $error("image_done: expected %0b, got %0b", want.image_done, image_done_o);
          err_cnt++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d runs outstanding",
               cycle_cnt, pending_runs.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Sequence of phases
  // --------------------------------------------------------------------------
  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed, at the reset sizes 640 x 480
    code_stream.push_back(8'd255);     // longest encoded run
    code_stream.push_back(8'hFF);
    code_stream.push_back(8'd1);       // shortest encoded run
    code_stream.push_back(8'h00);
    code_stream.push_back(ESC_INTRO);  // end of line mid-row
    code_stream.push_back(ESC_EOL);
    code_stream.push_back(ESC_INTRO);  // end of line at column zero
    code_stream.push_back(ESC_EOL);
    code_stream.push_back(ESC_INTRO);  // odd literal, then pad
    code_stream.push_back(LIT_MIN);
    code_stream.push_back(8'h01);
    code_stream.push_back(8'h80);
    code_stream.push_back(8'h7F);
    code_stream.push_back(8'hAA);
    code_stream.push_back(ESC_INTRO);  // delta of nothing
    code_stream.push_back(ESC_DELTA);
    code_stream.push_back(8'd0);
    code_stream.push_back(8'd0);
    code_stream.push_back(ESC_INTRO);  // delta right 5, down 1
    code_stream.push_back(ESC_DELTA);
    code_stream.push_back(8'd5);
    code_stream.push_back(8'd1);
    code_stream.push_back(ESC_INTRO);  // end of bitmap fills the rest
    code_stream.push_back(ESC_EOB);
    code_stream.push_back(ESC_INTRO);  // end of bitmap with image complete
    code_stream.push_back(ESC_EOB);

    // Zero sizes act as 1; image stays complete, runs all clip away
    wait_idle();
    set_size(13'd0, 13'd0);
    feed_stream(30, 255, 1'b0);

    // Single-pixel rows, short runs, runs clipped at the end
    wait_idle();
    set_size(13'd1, rows_ahead(120));
    feed_stream(60, 4, 1'b1);

    // Narrow image
    wait_idle();
    set_size(13'd7, rows_ahead(40));
    feed_stream(150, 16, 1'b1);

    // Mid-size width
    wait_idle();
    set_size(13'($urandom_range(100, 700)), rows_ahead(60));
    feed_stream(200, 255, 1'b0);

    // Width above the bound acts as the bound
    wait_idle();
    set_size(13'h1FFF, rows_ahead(20));
    feed_stream(200, 255, 1'b0);

    // Full bounds, height above the bound
    wait_idle();
    set_size(13'd4096, 13'h1FFF);
    feed_stream(200, 255, 1'b0);

    // Small image that finishes, then parsing on a complete image
    wait_idle();
    set_size(13'd13, rows_ahead(10));
    feed_stream(60, 255, 1'b1);

    wait_idle();
    if (pending_runs.size() != 0) begin
      $error("%0d predicted runs never came out", pending_runs.size());
      err_cnt++;
    end

    $display("Sent %0d code bytes over %0d size settings; %0d runs compared.",
             bytes_sent, size_sets, runs_seen);
    if (err_cnt == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches", err_cnt);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== bmp_rle8_run_decoder.f =====
rtl/core/brle8_pkg.sv
rtl/core/brle8_div.sv
rtl/core/bmp_rle8_run_decoder.sv
tb/tb.sv
